### rtl/bl2n_pkg.sv
// Shared types, constants and state encodings for the BF16 row L2 norm core.
// No dependencies; every other file refers to this package by scoped names.
package bl2n_pkg;

   localparam int unsigned     MAX_COLS_DEFAULT = 65536;
   localparam longint unsigned MAX_ROWS_DEFAULT = 64'd16777216;

   localparam int ELEMENT_WIDTH    = 16;
   localparam int ROW_LENGTH_WIDTH = 17;
   localparam int ROW_TOTAL_WIDTH  = 25;
   localparam int CSR_DATA_WIDTH   = 25;
   localparam int CSR_INDEX_WIDTH  = 1;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] POS_ZERO  = 64'h0000_0000_0000_0000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ROW_LENGTH = 1'b0,
      CSR_ROW_TOTAL  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [63:0] term;
      logic        close;
      logic        last;
   } item_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } add_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] sum;
   } add_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] operand;
   } root_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] root;
   } root_rsp_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_SUM,
      BACK_DIFF,
      BACK_CORR,
      BACK_COMP,
      BACK_TOTAL,
      BACK_ROOT
   } back_state_type;

   typedef enum logic [2:0] {
      ADD_IDLE,
      ADD_SWAP,
      ADD_SHIFT,
      ADD_SUM,
      ADD_COUNT,
      ADD_NORM,
      ADD_ROUND,
      ADD_DONE
   } add_state_type;

   typedef enum logic [2:0] {
      ROOT_IDLE,
      ROOT_NORM,
      ROOT_ITER,
      ROOT_ROUND,
      ROOT_DONE
   } root_state_type;

endpackage

### rtl/bl2n_front.sv
// Front end: configuration registers, column and row counters, BF16 squaring.
// Classifies each item (row close, last row) and pushes it into the queue; uses bl2n_pkg.
module bl2n_front #(
   parameter int unsigned     MAX_COLS = bl2n_pkg::MAX_COLS_DEFAULT,
   parameter longint unsigned MAX_ROWS = bl2n_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [bl2n_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bl2n_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [bl2n_pkg::ELEMENT_WIDTH-1:0]    req_element_bits,
   input  logic                                  queue_full,
   output logic                                  push,
   output bl2n_pkg::item_type                    push_item
);

   localparam int COL_W = $clog2(MAX_COLS + 1);
   localparam int ROW_W = $clog2(MAX_ROWS + 64'd1);

   logic [bl2n_pkg::ROW_LENGTH_WIDTH-1:0] row_length_ff;
   logic [bl2n_pkg::ROW_TOTAL_WIDTH-1:0]  row_total_ff;
   logic [COL_W-1:0]                      col_ff;
   logic [ROW_W-1:0]                      row_ff;
   logic [COL_W-1:0]                      cols_eff;
   logic [ROW_W-1:0]                      rows_eff;
   logic                                  close;
   logic                                  last;

   function automatic logic [63:0] bf16_square(input logic [15:0] raw);
      logic [7:0]         e8;
      logic [6:0]         m7;
      logic [7:0]         mant;
      logic [15:0]        prod;
      logic [3:0]         lead;
      logic signed [11:0] eu;
      logic signed [11:0] biased;
      logic [67:0]        wide;
      logic [63:0]        res;
      e8 = raw[14:7];
      m7 = raw[6:0];
      mant = {(e8 != 8'd0), m7};
      prod = mant * mant;
      lead = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (prod[i]) lead = 4'(i);
      end
      if (e8 != 8'd0) eu = $signed({4'b0, e8}) - 12'sd127;
      else eu = -12'sd126;
      biased = $signed({8'b0, lead}) + (eu <<< 1) - 12'sd14 + 12'sd1023;
      wide = 68'(prod) << (6'd52 - {2'b0, lead});
      if (e8 == 8'hFF) begin
         res = (m7 != 7'd0) ? bl2n_pkg::CANON_NAN : bl2n_pkg::POS_INF;
      end else if (e8 == 8'd0 && m7 == 7'd0) begin
         res = bl2n_pkg::POS_ZERO;
      end else begin
         res = {1'b0, biased[10:0], wide[51:0]};
      end
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= bl2n_pkg::ROW_LENGTH_WIDTH'(1);
         row_total_ff  <= bl2n_pkg::ROW_TOTAL_WIDTH'(1);
      end else if (csr_write) begin
         unique case (bl2n_pkg::csr_index_type'(csr_index))
            bl2n_pkg::CSR_ROW_LENGTH: row_length_ff <= csr_data[bl2n_pkg::ROW_LENGTH_WIDTH-1:0];
            bl2n_pkg::CSR_ROW_TOTAL:  row_total_ff  <= csr_data[bl2n_pkg::ROW_TOTAL_WIDTH-1:0];
         endcase
      end
   end

   always_comb begin
      if (row_length_ff == '0) cols_eff = COL_W'(1);
      else if (64'(row_length_ff) > 64'(MAX_COLS)) cols_eff = COL_W'(MAX_COLS);
      else cols_eff = COL_W'(row_length_ff);
      if (row_total_ff == '0) rows_eff = ROW_W'(1);
      else if (64'(row_total_ff) > 64'(MAX_ROWS)) rows_eff = ROW_W'(MAX_ROWS);
      else rows_eff = ROW_W'(row_total_ff);
   end

   assign close     = (64'(col_ff) + 64'd1) >= 64'(cols_eff);
   assign last      = (64'(row_ff) + 64'd1) >= 64'(rows_eff);
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.term  = bf16_square(req_element_bits);
      push_item.close = close;
      push_item.last  = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (push) begin
         if (close) begin
            col_ff <= '0;
            row_ff <= last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

endmodule

### rtl/bl2n_queue.sv
// Short item queue between the front end and the accumulator back end.
// Depth from bl2n_pkg::QUEUE_DEPTH; carries bl2n_pkg::item_type.
module bl2n_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bl2n_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output bl2n_pkg::item_type pop_item,
   output logic               empty
);

   localparam int PTR_W = $clog2(bl2n_pkg::QUEUE_DEPTH);

   bl2n_pkg::item_type mem_ff [bl2n_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff;
   logic [PTR_W-1:0]   rd_ff;
   logic [PTR_W:0]     count_ff;

   assign full     = count_ff == (PTR_W+1)'(bl2n_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(bl2n_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(bl2n_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         if (push && !pop) count_ff <= count_ff + (PTR_W+1)'(1);
         else if (pop && !push) count_ff <= count_ff - (PTR_W+1)'(1);
      end
   end

endmodule

### rtl/bl2n_fadd.sv
// Multi-cycle float64 adder with round-to-nearest-even and IEEE special values.
// Started by a request struct, answers with a one-cycle done; uses bl2n_pkg.
module bl2n_fadd (
   input  logic                  clock,
   input  logic                  reset,
   input  bl2n_pkg::add_req_type req,
   output bl2n_pkg::add_rsp_type rsp
);

   bl2n_pkg::add_state_type state_ff, state_in;

   logic [63:0] a_ff, b_ff, res_ff;
   logic [55:0] bm_ff, sm_ff, n_ff;
   logic [56:0] sum_ff;
   logic [11:0] xe_ff, d_ff, en_ff;
   logic [5:0]  shamt_ff;
   logic        sg_ff, sub_ff, zs_ff;

   logic [10:0] ea, eb;
   logic [51:0] fa, fb;
   logic [52:0] ma, mb;
   logic [11:0] xa, xb;
   logic        nan_a, nan_b, inf_a, inf_b, special, a_ge;
   logic [63:0] special_val;
   logic [55:0] sh, mask;
   logic        st;
   logic [5:0]  lz, shamt;
   logic        ru;
   logic [53:0] m54;
   logic [11:0] ef;
   logic [51:0] fr;
   logic [63:0] rounded;

   always_comb begin
      ea = a_ff[62:52];
      eb = b_ff[62:52];
      fa = a_ff[51:0];
      fb = b_ff[51:0];
      nan_a = (ea == 11'h7FF) && (fa != '0);
      nan_b = (eb == 11'h7FF) && (fb != '0);
      inf_a = (ea == 11'h7FF) && (fa == '0);
      inf_b = (eb == 11'h7FF) && (fb == '0);
      special = nan_a || nan_b || inf_a || inf_b;
      if (nan_a || nan_b || (inf_a && inf_b && (a_ff[63] != b_ff[63])))
         special_val = bl2n_pkg::CANON_NAN;
      else if (inf_a) special_val = a_ff;
      else special_val = b_ff;
      ma = {(ea != '0), fa};
      mb = {(eb != '0), fb};
      xa = (ea != '0) ? {1'b0, ea} : 12'd1;
      xb = (eb != '0) ? {1'b0, eb} : 12'd1;
      a_ge = {xa, ma} >= {xb, mb};
   end

   always_comb begin
      mask = ~({56{1'b1}} << d_ff[5:0]);
      if (d_ff >= 12'd56) begin
         sh = '0;
         st = |sm_ff;
      end else begin
         sh = sm_ff >> d_ff[5:0];
         st = |(sm_ff & mask);
      end
   end

   always_comb begin
      lz = 6'd0;
      for (int i = 0; i < 56; i++) begin
         if (sum_ff[i]) lz = 6'(55 - i);
      end
      if ({6'b0, lz} > (xe_ff - 12'd1)) shamt = 6'(xe_ff - 12'd1);
      else shamt = lz;
   end

   always_comb begin
      ru  = n_ff[2] && (n_ff[1] || n_ff[0] || n_ff[3]);
      m54 = {1'b0, n_ff[55:3]} + 54'(ru);
      if (m54[53]) begin
         ef = en_ff + 12'd1;
         fr = m54[52:1];
      end else begin
         ef = m54[52] ? en_ff : 12'd0;
         fr = m54[51:0];
      end
      if (ef >= 12'd2047) rounded = {sg_ff, 11'h7FF, 52'd0};
      else rounded = {sg_ff, ef[10:0], fr};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bl2n_pkg::ADD_IDLE:  if (req.start) state_in = bl2n_pkg::ADD_SWAP;
         bl2n_pkg::ADD_SWAP:  state_in = special ? bl2n_pkg::ADD_DONE : bl2n_pkg::ADD_SHIFT;
         bl2n_pkg::ADD_SHIFT: state_in = bl2n_pkg::ADD_SUM;
         bl2n_pkg::ADD_SUM:   state_in = bl2n_pkg::ADD_COUNT;
         bl2n_pkg::ADD_COUNT: begin
            if (sum_ff == '0) state_in = bl2n_pkg::ADD_DONE;
            else if (sum_ff[56]) state_in = bl2n_pkg::ADD_ROUND;
            else state_in = bl2n_pkg::ADD_NORM;
         end
         bl2n_pkg::ADD_NORM:  state_in = bl2n_pkg::ADD_ROUND;
         bl2n_pkg::ADD_ROUND: state_in = bl2n_pkg::ADD_DONE;
         bl2n_pkg::ADD_DONE:  state_in = bl2n_pkg::ADD_IDLE;
         default:             state_in = bl2n_pkg::ADD_IDLE;
      endcase
   end

   always_comb begin
      rsp.done = state_ff == bl2n_pkg::ADD_DONE;
      rsp.sum  = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bl2n_pkg::ADD_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         bl2n_pkg::ADD_IDLE: begin
            a_ff <= req.a;
            b_ff <= req.b;
         end
         bl2n_pkg::ADD_SWAP: begin
            res_ff <= special_val;
            sub_ff <= a_ff[63] ^ b_ff[63];
            zs_ff  <= a_ff[63] & b_ff[63];
            if (a_ge) begin
               bm_ff <= {ma, 3'b0};
               sm_ff <= {mb, 3'b0};
               xe_ff <= xa;
               d_ff  <= xa - xb;
               sg_ff <= a_ff[63];
            end else begin
               bm_ff <= {mb, 3'b0};
               sm_ff <= {ma, 3'b0};
               xe_ff <= xb;
               d_ff  <= xb - xa;
               sg_ff <= b_ff[63];
            end
         end
         bl2n_pkg::ADD_SHIFT: sm_ff <= {sh[55:1], sh[0] | st};
         bl2n_pkg::ADD_SUM: begin
            if (sub_ff) sum_ff <= {1'b0, bm_ff} - {1'b0, sm_ff};
            else sum_ff <= {1'b0, bm_ff} + {1'b0, sm_ff};
         end
         bl2n_pkg::ADD_COUNT: begin
            res_ff   <= {zs_ff, 63'd0};
            shamt_ff <= shamt;
            n_ff     <= {sum_ff[56:2], sum_ff[1] | sum_ff[0]};
            en_ff    <= xe_ff + 12'd1;
         end
         bl2n_pkg::ADD_NORM: begin
            n_ff  <= sum_ff[55:0] << shamt_ff;
            en_ff <= xe_ff - {6'b0, shamt_ff};
         end
         bl2n_pkg::ADD_ROUND: res_ff <= rounded;
         default: ;
      endcase
   end

endmodule

### rtl/bl2n_fsqrt.sv
// Iterative float64 square root, one result bit per cycle, correctly rounded.
// Started by a request struct, answers with a one-cycle done; uses bl2n_pkg.
module bl2n_fsqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  bl2n_pkg::root_req_type req,
   output bl2n_pkg::root_rsp_type rsp
);

   bl2n_pkg::root_state_type state_ff, state_in;

   logic [53:0]        m_ff, mr_ff, q_ff;
   logic [57:0]        rem_ff;
   logic signed [12:0] e_ff;
   logic [5:0]         cnt_ff;
   logic [63:0]        res_ff;

   logic [10:0]        expf;
   logic [51:0]        frac;
   logic               special;
   logic [63:0]        special_val;
   logic [57:0]        rem_next, trial;
   logic               take;
   logic [52:0]        mant;
   logic               ru;
   logic [53:0]        m54;
   logic signed [12:0] e2, expo;
   logic [51:0]        fr;

   always_comb begin
      expf = req.operand[62:52];
      frac = req.operand[51:0];
      special = 1'b1;
      if (expf == 11'h7FF) begin
         if (frac != '0 || req.operand[63]) special_val = bl2n_pkg::CANON_NAN;
         else special_val = req.operand;
      end else if (expf == '0 && frac == '0) begin
         special_val = req.operand;
      end else if (req.operand[63]) begin
         special_val = bl2n_pkg::CANON_NAN;
      end else begin
         special_val = req.operand;
         special = 1'b0;
      end
   end

   always_comb begin
      rem_next = {rem_ff[55:0], mr_ff[53:52]};
      trial    = {2'b00, q_ff, 2'b01};
      take     = rem_next >= trial;
   end

   always_comb begin
      mant = q_ff[53:1];
      ru   = q_ff[0] && ((rem_ff != '0) || mant[0]);
      m54  = {1'b0, mant} + 54'(ru);
      e2   = (e_ff >>> 1) - 13'sd26;
      if (m54[53]) begin
         expo = e2 + 13'sd1076;
         fr   = m54[52:1];
      end else begin
         expo = e2 + 13'sd1075;
         fr   = m54[51:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bl2n_pkg::ROOT_IDLE: begin
            if (req.start) state_in = special ? bl2n_pkg::ROOT_DONE : bl2n_pkg::ROOT_NORM;
         end
         bl2n_pkg::ROOT_NORM:  if (m_ff[52]) state_in = bl2n_pkg::ROOT_ITER;
         bl2n_pkg::ROOT_ITER:  if (cnt_ff == 6'd53) state_in = bl2n_pkg::ROOT_ROUND;
         bl2n_pkg::ROOT_ROUND: state_in = bl2n_pkg::ROOT_DONE;
         bl2n_pkg::ROOT_DONE:  state_in = bl2n_pkg::ROOT_IDLE;
         default:              state_in = bl2n_pkg::ROOT_IDLE;
      endcase
   end

   always_comb begin
      rsp.done = state_ff == bl2n_pkg::ROOT_DONE;
      rsp.root = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bl2n_pkg::ROOT_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         bl2n_pkg::ROOT_IDLE: begin
            res_ff <= special_val;
            if (expf != '0) begin
               m_ff <= {2'b01, frac};
               e_ff <= $signed({2'b00, expf}) - 13'sd1075;
            end else begin
               m_ff <= {2'b00, frac};
               e_ff <= -13'sd1074;
            end
         end
         bl2n_pkg::ROOT_NORM: begin
            if (!m_ff[52]) begin
               m_ff <= m_ff << 1;
               e_ff <= e_ff - 13'sd1;
            end else begin
               if (e_ff[0]) begin
                  mr_ff <= m_ff << 1;
                  e_ff  <= e_ff - 13'sd1;
               end else begin
                  mr_ff <= m_ff;
               end
               q_ff   <= '0;
               rem_ff <= '0;
               cnt_ff <= '0;
            end
         end
         bl2n_pkg::ROOT_ITER: begin
            rem_ff <= take ? rem_next - trial : rem_next;
            q_ff   <= {q_ff[52:0], take};
            mr_ff  <= mr_ff << 2;
            cnt_ff <= cnt_ff + 6'd1;
         end
         bl2n_pkg::ROOT_ROUND: res_ff <= {1'b0, expo[10:0], fr};
         default: ;
      endcase
   end

endmodule

### rtl/bl2n_back.sv
// Back end: Neumaier compensated accumulation over the shared adder, row close
// through the square root unit, and the result register; uses bl2n_pkg.
module bl2n_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   queue_empty,
   output logic                   pop,
   input  bl2n_pkg::item_type     pop_item,
   output bl2n_pkg::add_req_type  add_req,
   input  bl2n_pkg::add_rsp_type  add_rsp,
   output bl2n_pkg::root_req_type root_req,
   input  bl2n_pkg::root_rsp_type root_rsp,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [63:0]            rsp_magnitude_bits,
   output logic                   rsp_final_row
);

   bl2n_pkg::back_state_type state_ff, state_in;

   logic [63:0] term_ff, s_ff, c_ff, t_ff, d_ff, total_ff, mag_ff;
   logic        close_ff, last_ff, wait_ff, rsp_valid_ff, final_ff;
   logic        s_big, op_state;
   logic [63:0] big, small_term;

   assign s_big      = s_ff[62:0] >= term_ff[62:0];
   assign big        = s_big ? s_ff : term_ff;
   assign small_term = s_big ? term_ff : s_ff;
   assign op_state   = (state_ff == bl2n_pkg::BACK_SUM) || (state_ff == bl2n_pkg::BACK_DIFF)
                    || (state_ff == bl2n_pkg::BACK_CORR) || (state_ff == bl2n_pkg::BACK_COMP)
                    || (state_ff == bl2n_pkg::BACK_TOTAL);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bl2n_pkg::BACK_IDLE:  if (!queue_empty) state_in = bl2n_pkg::BACK_SUM;
         bl2n_pkg::BACK_SUM:   if (add_rsp.done) state_in = bl2n_pkg::BACK_DIFF;
         bl2n_pkg::BACK_DIFF:  if (add_rsp.done) state_in = bl2n_pkg::BACK_CORR;
         bl2n_pkg::BACK_CORR:  if (add_rsp.done) state_in = bl2n_pkg::BACK_COMP;
         bl2n_pkg::BACK_COMP: begin
            if (add_rsp.done) state_in = close_ff ? bl2n_pkg::BACK_TOTAL : bl2n_pkg::BACK_IDLE;
         end
         bl2n_pkg::BACK_TOTAL: if (add_rsp.done) state_in = bl2n_pkg::BACK_ROOT;
         bl2n_pkg::BACK_ROOT:  if (root_rsp.done) state_in = bl2n_pkg::BACK_IDLE;
         default:              state_in = bl2n_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      pop = (state_ff == bl2n_pkg::BACK_IDLE) && !queue_empty;
      add_req.start = op_state && !wait_ff
                   && ((state_ff != bl2n_pkg::BACK_TOTAL) || !rsp_valid_ff);
      add_req.a = '0;
      add_req.b = '0;
      unique case (state_ff)
         bl2n_pkg::BACK_SUM: begin
            add_req.a = s_ff;
            add_req.b = term_ff;
         end
         bl2n_pkg::BACK_DIFF: begin
            add_req.a = big;
            add_req.b = {~t_ff[63], t_ff[62:0]};
         end
         bl2n_pkg::BACK_CORR: begin
            add_req.a = d_ff;
            add_req.b = small_term;
         end
         bl2n_pkg::BACK_COMP: begin
            add_req.a = c_ff;
            add_req.b = d_ff;
         end
         bl2n_pkg::BACK_TOTAL: begin
            add_req.a = s_ff;
            add_req.b = c_ff;
         end
         default: ;
      endcase
      root_req.start   = (state_ff == bl2n_pkg::BACK_ROOT) && !wait_ff;
      root_req.operand = total_ff;
      rsp_valid          = rsp_valid_ff;
      rsp_magnitude_bits = mag_ff;
      rsp_final_row      = final_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bl2n_pkg::BACK_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s_ff         <= bl2n_pkg::POS_ZERO;
         c_ff         <= bl2n_pkg::POS_ZERO;
      end else begin
         state_ff <= state_in;
         if (add_req.start || root_req.start) wait_ff <= 1'b1;
         else if (add_rsp.done || root_rsp.done) wait_ff <= 1'b0;
         if (root_rsp.done) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (add_rsp.done && state_ff == bl2n_pkg::BACK_COMP) begin
            c_ff <= add_rsp.sum;
            s_ff <= t_ff;
         end
         if (add_rsp.done && state_ff == bl2n_pkg::BACK_TOTAL) begin
            s_ff <= bl2n_pkg::POS_ZERO;
            c_ff <= bl2n_pkg::POS_ZERO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         term_ff  <= pop_item.term;
         close_ff <= pop_item.close;
         last_ff  <= pop_item.last;
      end
      if (add_rsp.done) begin
         case (state_ff)
            bl2n_pkg::BACK_SUM:   t_ff     <= add_rsp.sum;
            bl2n_pkg::BACK_DIFF:  d_ff     <= add_rsp.sum;
            bl2n_pkg::BACK_CORR:  d_ff     <= add_rsp.sum;
            bl2n_pkg::BACK_TOTAL: total_ff <= add_rsp.sum;
            default: ;
         endcase
      end
      if (root_rsp.done) begin
         mag_ff   <= root_rsp.root;
         final_ff <= last_ff;
      end
   end

   a_add_done_expected: assert property (@(posedge clock) disable iff (reset)
      add_rsp.done |-> (wait_ff && op_state))
      else $error("adder finished with no operation outstanding");

   a_root_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      root_rsp.done |-> (!rsp_valid_ff && state_ff == bl2n_pkg::BACK_ROOT))
      else $error("result loaded while the output register was occupied");

   a_cleared_for_next_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bl2n_pkg::BACK_ROOT) |-> (s_ff == bl2n_pkg::POS_ZERO && c_ff == bl2n_pkg::POS_ZERO))
      else $error("accumulators not cleared after row close");

   a_pop_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == bl2n_pkg::BACK_SUM && !wait_ff))
      else $error("queue entry taken outside of dispatch");

endmodule

### rtl/bf16_row_l2_norm_compensated_core.sv
// Row-wise L2 norm of a BF16 tensor with compensated float64 summation.
// Top level: wires the front end, queue, back end, adder and square root unit.
//
// Elements enter one per item in row-major order and are squared and queued at
// once; a four-entry queue lets input keep flowing while the back end works.
// Each element is dispatched from the queue and takes four passes through the
// one shared float64 adder; the back end takes the next element from the queue
// only when it is through with the one before.
// The last element of a row adds one more adder pass and the bit-serial square
// root, and the row result is held in an output register until taken; the
// closing adder pass waits while that register is occupied.
// No clearing pass follows reset.
module bf16_row_l2_norm_compensated_core #(
   parameter int unsigned     MAX_COLS = bl2n_pkg::MAX_COLS_DEFAULT,
   parameter longint unsigned MAX_ROWS = bl2n_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [bl2n_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bl2n_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bl2n_pkg::ELEMENT_WIDTH-1:0]   req_element_bits,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [63:0]                          rsp_magnitude_bits,
   output logic                                 rsp_final_row
);

   logic                   push, queue_full, pop, queue_empty;
   bl2n_pkg::item_type     push_item, pop_item;
   bl2n_pkg::add_req_type  add_req;
   bl2n_pkg::add_rsp_type  add_rsp;
   bl2n_pkg::root_req_type root_req;
   bl2n_pkg::root_rsp_type root_rsp;

   bl2n_front #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_element_bits(req_element_bits),
      .queue_full      (queue_full),
      .push            (push),
      .push_item       (push_item)
   );

   bl2n_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .full     (queue_full),
      .pop      (pop),
      .pop_item (pop_item),
      .empty    (queue_empty)
   );

   bl2n_fadd u_fadd (
      .clock(clock),
      .reset(reset),
      .req  (add_req),
      .rsp  (add_rsp)
   );

   bl2n_fsqrt u_fsqrt (
      .clock(clock),
      .reset(reset),
      .req  (root_req),
      .rsp  (root_rsp)
   );

   bl2n_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .pop               (pop),
      .pop_item          (pop_item),
      .add_req           (add_req),
      .add_rsp           (add_rsp),
      .root_req          (root_req),
      .root_rsp          (root_rsp),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_magnitude_bits(rsp_magnitude_bits),
      .rsp_final_row     (rsp_final_row)
   );

endmodule
